/* hdl/binary_to_decimal_digits_macros.svh */
// assertion macros for the binary to decimal digit converter
`ifndef BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define B2DD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: label failed");

// next-cycle implication, sampled on clock, quiet during reset
`define B2DD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

/* hdl/b2dd_pkg.sv */
package b2dd_pkg;

   localparam int DIGIT_W = 4;
   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic advance;
   } cell_ctrl_type;

endpackage

/* hdl/b2dd_cell.sv */
module b2dd_cell (
   input  logic                             clock,
   input  b2dd_pkg::cell_ctrl_type          ctrl,
   input  logic                             carry_in,
   input  logic [b2dd_pkg::DIGIT_W-1:0]     lower_digit,
   output logic                             carry_out,
   output logic [b2dd_pkg::DIGIT_W-1:0]     digit_out
);

   localparam logic [b2dd_pkg::DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [b2dd_pkg::DIGIT_W-1:0] DABBLE_ADD = 4'd3;

   logic [b2dd_pkg::DIGIT_W-1:0] digit_ff;
   logic [b2dd_pkg::DIGIT_W-1:0] digit_in;
   logic [b2dd_pkg::DIGIT_W-1:0] adjusted;

   // add three before the shift so the digit carries at ten
   assign adjusted  = (digit_ff >= DABBLE_LIMIT) ? digit_ff + DABBLE_ADD : digit_ff;
   assign carry_out = adjusted[b2dd_pkg::DIGIT_W-1];
   assign digit_out = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      priority if (ctrl.clear) begin
         digit_in = b2dd_pkg::DIGIT_ZERO;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[b2dd_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctrl.advance) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

/* hdl/binary_to_decimal_digits.sv */
// sequence: the number is shifted into the digit cell chain, leading zero digits are dropped, then digits leave
// no new number is taken until the last digit of the current one is loaded into the output register;
//   the cell chain takes one input bit per cycle, and one digit position per cycle when draining
// digits leave through an output register, one per cycle without back pressure
// reset: synchronous, clears the sequencer and output valid; digit cells are not reset
module binary_to_decimal_digits #(
   parameter int VALUE_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [63:0]                     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [b2dd_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                            rsp_last_digit
);

   localparam int DIGITS = (VALUE_BITS * 78) / 256 + 1;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int REMAIN_W = $clog2(DIGITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SEEK,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [VALUE_BITS-1:0]            shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [REMAIN_W-1:0]              remain_ff, remain_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [b2dd_pkg::CHAR_W-1:0]      digit_char_ff, digit_char_in;
   logic                             last_digit_ff, last_digit_in;
   b2dd_pkg::cell_ctrl_type          ctrl;
   logic [b2dd_pkg::DIGIT_W-1:0]     digit_q [DIGITS];
   logic                             carry [DIGITS];
   logic [b2dd_pkg::DIGIT_W-1:0]     top_digit;

   assign top_digit = digit_q[DIGITS-1];

   // digit cell chain, cell 0 least significant
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      logic                         cell_carry_in;
      logic [b2dd_pkg::DIGIT_W-1:0] cell_lower;

      if (i == 0) begin : g_first
         assign cell_carry_in = shift_ff[VALUE_BITS-1];
         assign cell_lower    = b2dd_pkg::DIGIT_ZERO;
      end else begin : g_rest
         assign cell_carry_in = carry[i-1];
         assign cell_lower    = digit_q[i-1];
      end

      b2dd_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .carry_in    (cell_carry_in),
         .lower_digit (cell_lower),
         .carry_out   (carry[i]),
         .digit_out   (digit_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      digit_char_in = digit_char_ff;
      last_digit_in = last_digit_ff;
      ctrl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               shift_in   = req_value[VALUE_BITS-1:0];
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS);
               ctrl.clear = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            shift_in    = shift_ff << 1;
            bit_cnt_in  = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               remain_in = REMAIN_W'(DIGITS);
               state_in  = ST_SEEK;
            end
         end
         ST_SEEK: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == b2dd_pkg::DIGIT_ZERO && remain_ff != REMAIN_W'(1)) begin
               ctrl.advance = 1'b1;
               remain_in    = remain_ff - REMAIN_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               digit_char_in = b2dd_pkg::CHAR_W'(top_digit) + b2dd_pkg::ASCII_ZERO;
               last_digit_in = (remain_ff == REMAIN_W'(1));
               ctrl.advance  = 1'b1;
               remain_in     = remain_ff - REMAIN_W'(1);
               if (remain_ff == REMAIN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff      <= shift_in;
      bit_cnt_ff    <= bit_cnt_in;
      remain_ff     <= remain_in;
      digit_char_ff <= digit_char_in;
      last_digit_ff <= last_digit_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = digit_char_ff;
   assign rsp_last_digit = last_digit_ff;

endmodule

/* hdl/b2dd_checker.sv */
`include "binary_to_decimal_digits_macros.svh"

module b2dd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [b2dd_pkg::CHAR_W-1:0]     rsp_digit_char,
   input logic                            rsp_last_digit
);

   logic req_fire;

   assign req_fire = req_valid & req_ready;

   // stalled result transaction holds
   `B2DD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last_digit))

   // only decimal characters leave
   `B2DD_ASSERT_IMPL(a_rsp_decimal, rsp_valid,
      rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57)

   // busy once a number is taken
   `B2DD_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready)

   // no new number while a run is still unfinished
   `B2DD_ASSERT_IMPL(a_run_blocks_req, rsp_valid && !rsp_last_digit, !req_ready)

endmodule

bind binary_to_decimal_digits b2dd_checker u_b2dd_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int VALUE_BITS = 64;
   localparam int MAX_DIGITS = 20;
   localparam int RANDOM_NUMBERS = 410;
   localparam int LIMIT_CYCLES = 2000000;
   localparam int TAIL_CYCLES = 120;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int LONG_HOLD_AT_DIGIT = 40;

   typedef struct packed {
      logic        drain_first;
      logic [63:0] number;
   } number_item_type;

   typedef struct packed {
      logic [b2dd_pkg::CHAR_W-1:0] digit_char;
      logic                        last_digit;
   } digit_item_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [63:0] req_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [b2dd_pkg::CHAR_W-1:0] rsp_digit_char;
   logic rsp_last_digit;

   logic req_taken;
   logic rsp_taken;

   number_item_type pending_numbers[$];
   digit_item_type expected_digits[$];

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned digits_received;
   int unsigned send_gap;
   int unsigned hold_left;
   bit          long_hold_done;
   bit          offering;

   binary_to_decimal_digits #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit)
   );

   // decimal digits of the masked number, most significant first
   function automatic void predict_digits(input logic [63:0] number);
      logic [63:0]    mask;
      logic [63:0]    rest;
      logic [3:0]     reversed[MAX_DIGITS];
      int             count;
      digit_item_type item;
      mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
      rest = number & mask;
      count = 0;
      do begin
         reversed[count] = 4'(rest % 64'd10);
         rest = rest / 64'd10;
         count++;
      end while (rest != 64'd0 && count < MAX_DIGITS);
      for (int k = 0; k < count; k++) begin
         item.digit_char = b2dd_pkg::ASCII_ZERO +
                           b2dd_pkg::CHAR_W'(reversed[count - 1 - k]);
         item.last_digit = (k == count - 1);
         expected_digits.push_back(item);
      end
   endfunction

   function automatic logic [63:0] power_of_ten(input int exponent);
      logic [63:0] result;
      result = 64'd1;
      for (int k = 0; k < exponent; k++)
         result = result * 64'd10;
      return result;
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if ((cycle_count / 1500) % 4 == 1)
         return 0;
      if (pick < 60)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      if (pick < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] random_number();
      logic [63:0] low_bound;
      logic [63:0] span;
      logic [63:0] raw;
      int          length;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            length = $urandom_range(1, MAX_DIGITS);
            low_bound = (length == 1) ? 64'd0 : power_of_ten(length - 1);
            if (length == MAX_DIGITS)
               span = ~low_bound + 64'd1;
            else
               span = power_of_ten(length) - low_bound;
            return low_bound + (raw % span);
         end
         4, 5: return raw;
         6, 7: return raw >> $urandom_range(1, 63);
         8: return 64'($urandom_range(0, 20));
         default: begin
            length = $urandom_range(1, MAX_DIGITS - 1);
            return power_of_ten(length) - 64'($urandom_range(0, 1));
         end
      endcase
   endfunction

   function automatic void queue_number(input logic [63:0] number, input logic drain_first);
      number_item_type item;
      item.number = number;
      item.drain_first = drain_first;
      pending_numbers.push_back(item);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // transaction source
   always @(negedge clock) begin
      logic        next_valid;
      logic [63:0] next_value;
      next_valid = req_valid;
      next_value = req_value;
      if (reset) begin
         next_valid = 1'b0;
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (offering && req_taken) begin
            void'(pending_numbers.pop_front());
            offering = 1'b0;
            send_gap = idle_length();
         end
         if (!offering) begin
            if (send_gap > 0)
               send_gap--;
            else if (pending_numbers.size() > 0 &&
                     (!pending_numbers[0].drain_first || expected_digits.size() == 0)) begin
               offering = 1'b1;
               next_value = pending_numbers[0].number;
            end
         end
         next_valid = offering;
         if (!offering)
            next_value = {$urandom, $urandom};
      end
      req_valid <= next_valid;
      req_value <= next_value;
   end

   // result sink with back pressure
   always @(negedge clock) begin
      logic next_ready;
      int unsigned gap;
      if (reset) begin
         next_ready = 1'b0;
         hold_left = 0;
      end else begin
         if (!long_hold_done && digits_received >= LONG_HOLD_AT_DIGIT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            next_ready = 1'b0;
            hold_left--;
         end else begin
            next_ready = 1'b1;
            if (rsp_taken) begin
               gap = idle_length();
               if (gap > 0) begin
                  next_ready = 1'b0;
                  hold_left = gap - 1;
               end
            end
         end
      end
      rsp_ready <= next_ready;
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      digit_item_type wanted;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && req_valid && req_ready)
         predict_digits(req_value);
      if (!reset && rsp_valid && rsp_ready) begin
         digits_received++;
         if (expected_digits.size() == 0) begin
            $error("unexpected digit transaction: digit_char %0d last_digit %0b",
                   rsp_digit_char, rsp_last_digit);
            mismatch_count++;
         end else begin
            wanted = expected_digits.pop_front();
            if (rsp_digit_char !== wanted.digit_char) begin
               $error("digit_char mismatch: expected %0d actual %0d",
                      wanted.digit_char, rsp_digit_char);
               mismatch_count++;
            end
            if (rsp_last_digit !== wanted.last_digit) begin
               $error("last_digit mismatch: expected %0b actual %0b",
                      wanted.last_digit, rsp_last_digit);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_value = 64'd0;
      rsp_ready = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      digits_received = 0;
      send_gap = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
      offering = 1'b0;

      // zero, digit boundaries, widest values and alternating bit patterns
      queue_number(64'd0, 1'b0);
      queue_number(64'd1, 1'b0);
      queue_number(64'd9, 1'b0);
      queue_number(64'd10, 1'b0);
      queue_number(64'd99, 1'b0);
      queue_number(64'd100, 1'b0);
      queue_number(64'd1234567890, 1'b0);
      queue_number(64'd10000000000, 1'b0);
      queue_number(power_of_ten(18), 1'b0);
      queue_number(power_of_ten(19) - 64'd1, 1'b0);
      queue_number(power_of_ten(19), 1'b0);
      queue_number(64'd12345678901234567890, 1'b0);
      queue_number(64'h8000_0000_0000_0000, 1'b0);
      queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      queue_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_number(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      queue_number(64'h5555_5555_5555_5555, 1'b0);
      queue_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_number(64'h0000_0001_0000_0000, 1'b0);
      queue_number(64'd0, 1'b0);

      for (int k = 0; k < RANDOM_NUMBERS; k++)
         queue_number(random_number(), k == 0 || k == RANDOM_NUMBERS / 2);

      do
         @(posedge clock);
      while (reset || pending_numbers.size() > 0 || expected_digits.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_digits.size() > 0) begin
         $error("%0d expected digits never arrived", expected_digits.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/b2dd_pkg.sv
hdl/b2dd_cell.sv
hdl/binary_to_decimal_digits.sv
hdl/b2dd_checker.sv
sim/tb.sv
